FILE: sv/lcsps_pkg.sv
// Shared types and constants for the LED counter / snake pattern selector.
package lcsps_pkg;

  localparam int SPEED_W     = 26;
  localparam int DEBOUNCE_W  = 20;
  localparam int WAIT_W      = 27;
  localparam int READING_W   = 10;
  localparam int LED_W       = 8;
  localparam int POS_W       = 3;
  localparam int LEVEL_W     = 3;
  localparam int NUM_LEVELS  = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 26;

  localparam int LEVEL_STEP = 205;

  localparam logic [LEVEL_W-1:0] LEVEL_ZERO  = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = 3'd4;
  localparam logic [LEVEL_W-1:0] LEVEL_ERROR = LEVEL_TWO;

  localparam logic [POS_W-1:0] SNAKE_TOP    = 3'd5;
  localparam logic [POS_W-1:0] SNAKE_BOTTOM = 3'd0;
  localparam logic [LED_W-1:0] SNAKE_BITS   = 8'h07;

  localparam logic PROG_COUNTER = 1'b0;
  localparam logic PROG_SNAKE   = 1'b1;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED0   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED1   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED2   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED3   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED4   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 3'd5;

  localparam logic [SPEED_W-1:0]    SPEED0_RESET   = 26'd2000000;
  localparam logic [SPEED_W-1:0]    SPEED1_RESET   = 26'd6000000;
  localparam logic [SPEED_W-1:0]    SPEED2_RESET   = 26'd12000000;
  localparam logic [SPEED_W-1:0]    SPEED3_RESET   = 26'd24000000;
  localparam logic [SPEED_W-1:0]    SPEED4_RESET   = 26'd40000000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 20'd40000;

  typedef struct packed {
    logic                          program_select;
    logic [LED_W-1:0]              binary_count;
    logic [POS_W-1:0]              snake_position;
    logic                          snake_moving_down;
    logic                          forward_last_level;
    logic                          backward_last_level;
  } state_t;

  typedef struct packed {
    logic [NUM_LEVELS-1:0][SPEED_W-1:0] speed_wait;
    logic [DEBOUNCE_W-1:0]              debounce_wait;
  } cfg_t;

  typedef struct packed {
    logic [READING_W-1:0] pot_reading;
    logic                 pot_error;
    logic                 forward_button_level;
    logic                 backward_button_level;
  } pass_t;

  typedef struct packed {
    logic [LED_W-1:0]  led_pattern;
    logic [WAIT_W-1:0] wait_cycles;
    logic              active_program;
  } result_t;

endpackage

FILE: sv/lcsps_in_if.sv
// Input channel: one main-loop pass with pot reading and button levels.
interface lcsps_in_if;
  import lcsps_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [READING_W-1:0] pot_reading;
  logic                 pot_error;
  logic                 forward_button_level;
  logic                 backward_button_level;

  modport source (
    output valid, pot_reading, pot_error, forward_button_level, backward_button_level,
    input  ready
  );

  modport sink (
    input  valid, pot_reading, pot_error, forward_button_level, backward_button_level,
    output ready
  );
endinterface

FILE: sv/lcsps_out_if.sv
// Output channel: LED byte, wait count and active program of one pass.
interface lcsps_out_if;
  import lcsps_pkg::*;

  logic              valid;
  logic              ready;
  logic [LED_W-1:0]  led_pattern;
  logic [WAIT_W-1:0] wait_cycles;
  logic              active_program;

  modport source (
    output valid, led_pattern, wait_cycles, active_program,
    input  ready
  );

  modport sink (
    input  valid, led_pattern, wait_cycles, active_program,
    output ready
  );
endinterface

FILE: sv/led_counter_snake_pattern_selector_top.sv
// Each accepted item's result is registered in a two-entry result buffer.
// Throughput: one item per cycle while the output is not stalled; the
// buffer keeps the input open for one more item while output is stalled.
// Reset (rst, synchronous): pattern state cleared, buttons seen as released,
// registers at their default waits, result buffer emptied.
module led_counter_snake_pattern_selector_top
  import lcsps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lcsps_in_if.sink               pass,
  lcsps_out_if.source            result
);

  state_t  state;
  state_t  state_next;
  cfg_t    cfg;
  pass_t   pass_item;
  result_t step_result;
  result_t out_reg;
  result_t skid_reg;
  logic    out_valid;
  logic    skid_valid;
  logic    accept;
  logic    take;

  assign pass_item.pot_reading           = pass.pot_reading;
  assign pass_item.pot_error             = pass.pot_error;
  assign pass_item.forward_button_level  = pass.forward_button_level;
  assign pass_item.backward_button_level = pass.backward_button_level;

  assign pass.ready = ~skid_valid;
  assign accept     = pass.valid & pass.ready;
  assign take       = out_valid & result.ready;

  lcsps_step u_step (
    .state      (state),
    .cfg        (cfg),
    .pass       (pass_item),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_wait[0] <= SPEED0_RESET;
      cfg.speed_wait[1] <= SPEED1_RESET;
      cfg.speed_wait[2] <= SPEED2_RESET;
      cfg.speed_wait[3] <= SPEED3_RESET;
      cfg.speed_wait[4] <= SPEED4_RESET;
      cfg.debounce_wait <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SPEED0:   cfg.speed_wait[0] <= cfg_data[SPEED_W-1:0];
        REG_SPEED1:   cfg.speed_wait[1] <= cfg_data[SPEED_W-1:0];
        REG_SPEED2:   cfg.speed_wait[2] <= cfg_data[SPEED_W-1:0];
        REG_SPEED3:   cfg.speed_wait[3] <= cfg_data[SPEED_W-1:0];
        REG_SPEED4:   cfg.speed_wait[4] <= cfg_data[SPEED_W-1:0];
        REG_DEBOUNCE: cfg.debounce_wait <= cfg_data[DEBOUNCE_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.program_select      <= 1'b0;
      state.binary_count        <= '0;
      state.snake_position      <= '0;
      state.snake_moving_down   <= 1'b0;
      state.forward_last_level  <= 1'b1;
      state.backward_last_level <= 1'b1;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Two-entry result buffer: output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_reg <= step_result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_reg   <= step_result;
        skid_valid <= 1'b1;
      end else begin
        out_reg   <= step_result;
        out_valid <= 1'b1;
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.led_pattern    = out_reg.led_pattern;
  assign result.wait_cycles    = out_reg.wait_cycles;
  assign result.active_program = out_reg.active_program;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_snake_in_range: assert property (@(posedge clk) disable iff (rst)
    state.snake_position <= SNAKE_TOP)
    else $error("snake position beyond top");

  a_program_matches: assert property (@(posedge clk) disable iff (rst)
    (accept && !out_valid) |=> (result.active_program == state.program_select))
    else $error("result program differs from selected program");

endmodule

FILE: sv/lcsps_step.sv
// Next-state and result logic for one main-loop pass.
module lcsps_step
  import lcsps_pkg::*;
(
  input  state_t  state,
  input  cfg_t    cfg,
  input  pass_t   pass,
  output state_t  state_next,
  output result_t result
);

  logic [LEVEL_W-1:0] level;
  logic               fwd_hit;
  logic               bwd_hit;
  logic               any_hit;
  logic               prog;
  logic [LED_W-1:0]   count_cur;
  logic [POS_W-1:0]   pos_cur;
  logic               down_cur;
  logic [POS_W-1:0]   pos_new;
  logic [WAIT_W-1:0]  debounce_ext;

  // Speed level: reading / 205 clamped to four, as a compare ladder; a pot error selects level two
  always_comb begin
    priority if (pass.pot_error) begin
      level = LEVEL_ERROR;
    end else if (pass.pot_reading >= READING_W'(4 * LEVEL_STEP)) begin
      level = LEVEL_FOUR;
    end else if (pass.pot_reading >= READING_W'(3 * LEVEL_STEP)) begin
      level = LEVEL_THREE;
    end else if (pass.pot_reading >= READING_W'(2 * LEVEL_STEP)) begin
      level = LEVEL_TWO;
    end else if (pass.pot_reading >= READING_W'(LEVEL_STEP)) begin
      level = LEVEL_ONE;
    end else begin
      level = LEVEL_ZERO;
    end
  end

  assign fwd_hit = state.forward_last_level & ~pass.forward_button_level;
  assign bwd_hit = state.backward_last_level & ~pass.backward_button_level;
  assign any_hit = fwd_hit | bwd_hit;

  // Each press toggles the program, so two presses cancel out
  assign prog      = state.program_select ^ fwd_hit ^ bwd_hit;
  assign count_cur = any_hit ? '0 : state.binary_count;
  assign pos_cur   = any_hit ? '0 : state.snake_position;
  assign down_cur  = any_hit ? 1'b0 : state.snake_moving_down;
  assign pos_new   = down_cur ? pos_cur - POS_W'(1) : pos_cur + POS_W'(1);

  assign debounce_ext = WAIT_W'(cfg.debounce_wait);

  always_comb begin
    state_next                     = state;
    state_next.program_select      = prog;
    state_next.forward_last_level  = pass.forward_button_level;
    state_next.backward_last_level = pass.backward_button_level;
    state_next.binary_count        = count_cur;
    state_next.snake_position      = pos_cur;
    state_next.snake_moving_down   = down_cur;

    result.active_program = prog;
    result.wait_cycles    = WAIT_W'(cfg.speed_wait[level])
                          + (fwd_hit ? debounce_ext : '0)
                          + (bwd_hit ? debounce_ext : '0);

    unique case (prog)
      PROG_COUNTER: begin
        result.led_pattern      = count_cur;
        state_next.binary_count = count_cur + LED_W'(1);
      end
      PROG_SNAKE: begin
        result.led_pattern        = SNAKE_BITS << pos_cur;
        state_next.snake_position = pos_new;
        // Flip direction on reaching either end
        if (pos_new == SNAKE_TOP || pos_new == SNAKE_BOTTOM) begin
          state_next.snake_moving_down = ~down_cur;
        end
      end
      default: begin
        result.led_pattern = count_cur;
      end
    endcase
  end

endmodule
